FILE: hw/rtl/polv_pkg.sv
// shared types and constants for the per-object label vote unit
package polv_pkg;

  localparam int SLOT_W  = 10;
  localparam int LABEL_W = 8;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // control sequence of the unit
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } vote_state_t;

  // one winner entry per object
  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [COUNT_W-1:0] count;
  } win_entry_t;

  // result of one vote update
  typedef struct packed {
    logic [COUNT_W-1:0] bin;
    win_entry_t         win;
    logic               changed;
  } vote_upd_t;

endpackage

FILE: hw/rtl/polv_sync_ram.sv
// single write port, single registered read port memory
module polv_sync_ram #(
  parameter int WIDTH = 16,
  parameter int AW    = 18,
  parameter int DEPTH = 262144
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/polv_vote_calc.sv
// bin increment and plurality winner update for one vote
module polv_vote_calc
  import polv_pkg::*;
(
  input  logic [LABEL_W-1:0] label,
  input  logic [COUNT_W-1:0] bin_old,
  input  win_entry_t         win_old,
  output vote_upd_t          upd
);

  logic [COUNT_W-1:0] bin_new;

  // saturating bin increment
  assign bin_new = (bin_old == COUNT_MAX) ? bin_old : bin_old + COUNT_W'(1);

  // winner follows its own bin, challenger takes over only when strictly ahead
  always_comb begin
    upd.bin     = bin_new;
    upd.win     = win_old;
    upd.changed = 1'b0;
    priority if (win_old.label == label) begin
      upd.win.count = (win_old.count == COUNT_MAX) ? win_old.count
                                                   : win_old.count + COUNT_W'(1);
    end else if (bin_new > win_old.count) begin
      upd.win.label = label;
      upd.win.count = bin_new;
      upd.changed   = 1'b1;
    end else begin
      // tie or behind: old winner stays
      upd.win = win_old;
    end
  end

endmodule

FILE: hw/rtl/per_object_label_vote_unit.sv
// top level of the per-object label vote unit: control, memories and result register
//
// Usage: each item is one observation (object_slot, label). An item is taken at a
// rising edge where start is high and busy is low. The unit adds one vote to the
// object's bin for that label and updates the object's running plurality winner.
// Exactly one result per item appears on winner_label, winner_count, bin_count and
// winner_changed, marked by result_valid for a single cycle; the receiver cannot
// stall it.
// Timing: the accepting edge captures the item and the bin and winner memory reads
// and moves the unit into the write-back state ST_EXEC; result_valid and the result
// are registered out of ST_EXEC. busy is high in ST_EXEC, so the unit takes no new
// item until the previous one is written back; busy covers the read-modify-write,
// so two items never touch the same entry at once.
// Reset: rst is synchronous. After reset the unit sweeps both memories to zero,
// one bin entry per cycle, over all NUM_OBJECTS * 2**ceil(log2(NUM_LABELS)) bin
// entries (262144 at the defaults); busy stays high for the whole sweep.
// Slots at or above NUM_OBJECTS give an all-zero result; labels at or above
// NUM_LABELS report the current winner with a zero bin count; neither changes state.
module per_object_label_vote_unit
  import polv_pkg::*;
#(
  parameter int NUM_OBJECTS = 1024,
  parameter int NUM_LABELS  = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [SLOT_W-1:0]  object_slot,
  input  logic [LABEL_W-1:0] label,
  output logic               result_valid,
  output logic [LABEL_W-1:0] winner_label,
  output logic [COUNT_W-1:0] winner_count,
  output logic [COUNT_W-1:0] bin_count,
  output logic               winner_changed
);

  localparam int OBJ_AW    = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int LAB_AW    = $clog2(NUM_LABELS);
  localparam int BIN_DEPTH = NUM_OBJECTS * (2 ** LAB_AW);
  localparam int BIN_AW    = $clog2(BIN_DEPTH);
  localparam int WIN_W     = $bits(win_entry_t);

  vote_state_t        state, state_next;
  logic [BIN_AW-1:0]  clr_addr;
  logic               clr_last;
  logic               accept;

  logic [OBJ_AW-1:0]  slot_q;
  logic [LAB_AW-1:0]  lab_idx_q;
  logic [LABEL_W-1:0] label_q;
  logic               slot_ok_q;
  logic               lab_ok_q;

  logic [OBJ_AW+SLOT_W-1:0] slot_ext;
  logic               slot_ok;
  logic               lab_ok;

  logic               bin_we;
  logic [BIN_AW-1:0]  bin_waddr;
  logic [COUNT_W-1:0] bin_wdata;
  logic [BIN_AW-1:0]  bin_raddr;
  logic [COUNT_W-1:0] bin_rdata;

  logic               win_we;
  logic [OBJ_AW-1:0]  win_waddr;
  win_entry_t         win_wdata;
  win_entry_t         win_rdata;
  logic [WIN_W-1:0]   win_rdata_raw;

  vote_upd_t          upd;

  // input decode
  assign accept   = start && !busy;
  assign slot_ext = {{OBJ_AW{1'b0}}, object_slot};
  assign slot_ok  = (17'(object_slot) < 17'(NUM_OBJECTS));
  assign lab_ok   = ({1'b0, label} < 9'(NUM_LABELS));
  assign clr_last = (clr_addr == BIN_AW'(BIN_DEPTH - 1));

  // read address comes straight from the ports on the accepting cycle
  assign bin_raddr = BIN_AW'({slot_ext[OBJ_AW-1:0], label[LAB_AW-1:0]});

  // state register and clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + BIN_AW'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (start)    state_next = ST_EXEC;
      ST_EXEC:                state_next = ST_IDLE;
      default:                state_next = ST_CLEAR;
    endcase
  end

  // memory control and busy
  always_comb begin
    busy      = 1'b1;
    bin_we    = 1'b0;
    bin_waddr = BIN_AW'({slot_q, lab_idx_q});
    bin_wdata = upd.bin;
    win_we    = 1'b0;
    win_waddr = slot_q;
    win_wdata = upd.win;
    unique case (state)
      ST_CLEAR: begin
        bin_we    = 1'b1;
        bin_waddr = clr_addr;
        bin_wdata = '0;
        win_we    = ((BIN_AW+1)'(clr_addr) < (BIN_AW+1)'(NUM_OBJECTS));
        win_waddr = clr_addr[OBJ_AW-1:0];
        win_wdata = '0;
      end
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_EXEC: begin
        bin_we = slot_ok_q && lab_ok_q;
        win_we = slot_ok_q && lab_ok_q;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_q    <= slot_ext[OBJ_AW-1:0];
      lab_idx_q <= label[LAB_AW-1:0];
      label_q   <= label;
      slot_ok_q <= slot_ok;
      lab_ok_q  <= lab_ok;
    end
  end

  // vote bin store
  polv_sync_ram #(
    .WIDTH (COUNT_W),
    .AW    (BIN_AW),
    .DEPTH (BIN_DEPTH)
  ) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  // winner store
  polv_sync_ram #(
    .WIDTH (WIN_W),
    .AW    (OBJ_AW),
    .DEPTH (NUM_OBJECTS)
  ) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .raddr (slot_ext[OBJ_AW-1:0]),
    .rdata (win_rdata_raw)
  );

  assign win_rdata = win_entry_t'(win_rdata_raw);

  // vote update
  polv_vote_calc u_calc (
    .label   (label_q),
    .bin_old (bin_rdata),
    .win_old (win_rdata),
    .upd     (upd)
  );

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_EXEC);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      priority if (!slot_ok_q) begin
        winner_label   <= '0;
        winner_count   <= '0;
        bin_count      <= '0;
        winner_changed <= 1'b0;
      end else if (!lab_ok_q) begin
        winner_label   <= win_rdata.label;
        winner_count   <= win_rdata.count;
        bin_count      <= '0;
        winner_changed <= 1'b0;
      end else begin
        winner_label   <= upd.win.label;
        winner_count   <= upd.win.count;
        bin_count      <= upd.bin;
        winner_changed <= upd.changed;
      end
    end
  end

  // a result only follows a write-back cycle
  a_result_after_exec: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_EXEC))
    else $error("result strobe without a preceding update cycle");

  // every accepted item yields a result, strobed out of its write-back state
  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 result_valid)
    else $error("accepted item produced no result");

  // memories are never written while the unit reports idle
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (bin_we || win_we) |-> (state != ST_IDLE))
    else $error("memory write while idle");

  // a new winner always carries the count of the bin that won
  a_change_consistent: assert property (@(posedge clk) disable iff (rst)
    (result_valid && winner_changed) |-> (bin_count == winner_count))
    else $error("winner change with mismatched counts");

endmodule

FILE: test/per_object_label_vote_checker.sv
// checker for the per-object label vote unit: predicts each vote and compares results
module per_object_label_vote_checker
  import polv_pkg::*;
#(
  parameter int NUM_OBJECTS = 1024,
  parameter int NUM_LABELS  = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [SLOT_W-1:0]  object_slot,
  input  logic [LABEL_W-1:0] label,
  input  logic               result_valid,
  input  logic [LABEL_W-1:0] winner_label,
  input  logic [COUNT_W-1:0] winner_count,
  input  logic [COUNT_W-1:0] bin_count,
  input  logic               winner_changed,
  output int                 mismatches,
  output int                 outstanding,
  output int                 results_seen,
  output int                 changes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_CAP = 40;

  // expected fields of one result
  typedef struct packed {
    logic [LABEL_W-1:0] win_label;
    logic [COUNT_W-1:0] win_count;
    logic [COUNT_W-1:0] bin;
    logic               changed;
  } vote_tally_t;

  // shadow histograms and running winners
  bit [COUNT_W-1:0] vote_bins [NUM_OBJECTS*NUM_LABELS];
  bit [LABEL_W-1:0] lead_label [NUM_OBJECTS];
  bit [COUNT_W-1:0] lead_count [NUM_OBJECTS];

  vote_tally_t pending_votes [$];
  vote_tally_t want;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
    changes_seen = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_CAP) begin
      $display("vote mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  // apply one vote to the shadow state and return what the unit should report
  function automatic vote_tally_t tally_vote(input logic [SLOT_W-1:0] slot,
                                             input logic [LABEL_W-1:0] lab);
    vote_tally_t      t;
    int unsigned      idx;
    logic [COUNT_W-1:0] bin;
    t = '0;
    // slot outside the table: all-zero result, nothing changes
    if (slot >= NUM_OBJECTS) return t;
    // label outside the table: report current winner only
    if (lab >= NUM_LABELS) begin
      t.win_label = lead_label[slot];
      t.win_count = lead_count[slot];
      return t;
    end
    idx = int'(slot) * NUM_LABELS + int'(lab);
    bin = vote_bins[idx];
    if (bin != COUNT_MAX) bin = bin + 1'b1;
    vote_bins[idx] = bin;
    // winner follows its own bin; a challenger must strictly exceed it
    if (lead_label[slot] == lab) begin
      if (lead_count[slot] != COUNT_MAX) lead_count[slot] = lead_count[slot] + 1'b1;
    end else if (bin > lead_count[slot]) begin
      lead_label[slot] = lab;
      lead_count[slot] = bin;
      t.changed = 1'b1;
    end
    t.win_label = lead_label[slot];
    t.win_count = lead_count[slot];
    t.bin       = bin;
    return t;
  endfunction

  // watch both channels at every edge
  always @(posedge clk) begin
    if (rst) begin
      foreach (vote_bins[i]) vote_bins[i] = '0;
      foreach (lead_label[i]) begin
        lead_label[i] = '0;
        lead_count[i] = '0;
      end
      pending_votes.delete();
    end else begin
      // result side first: a result never belongs to an item taken at this edge
      if (result_valid) begin
        if (pending_votes.size() == 0) begin
          report_mismatch("result with no vote outstanding");
        end else begin
          want = pending_votes.pop_front();
          results_seen++;
          if (want.changed) changes_seen++;
          if (winner_label !== want.win_label)
            report_mismatch($sformatf("winner_label got %0d want %0d",
                                      winner_label, want.win_label));
          if (winner_count !== want.win_count)
            report_mismatch($sformatf("winner_count got %0d want %0d",
                                      winner_count, want.win_count));
          if (bin_count !== want.bin)
            report_mismatch($sformatf("bin_count got %0d want %0d",
                                      bin_count, want.bin));
          if (winner_changed !== want.changed)
            report_mismatch($sformatf("winner_changed got %0b want %0b",
                                      winner_changed, want.changed));
        end
      end
      // accepted vote goes to the tail of the queue
      if (start && !busy) begin
        pending_votes.insert(pending_votes.size(), tally_vote(object_slot, label));
      end
    end
    outstanding <= pending_votes.size();
  end

endmodule

FILE: test/per_object_label_vote_unit_test.sv
// testbench top for the per-object label vote unit: clock, reset, vote stimulus, verdict
module per_object_label_vote_unit_test
  import polv_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_OBJECTS = 1024;
  localparam int NUM_LABELS  = 256;
  localparam int HOT         = 4;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [SLOT_W-1:0]  object_slot;
  logic [LABEL_W-1:0] label;
  logic               result_valid;
  logic [LABEL_W-1:0] winner_label;
  logic [COUNT_W-1:0] winner_count;
  logic [COUNT_W-1:0] bin_count;
  logic               winner_changed;

  int mismatches;
  int outstanding;
  int results_seen;
  int changes_seen;
  int votes_cast;

  logic [SLOT_W-1:0]  hot_slots  [HOT];
  logic [LABEL_W-1:0] hot_labels [HOT];

  per_object_label_vote_unit #(
    .NUM_OBJECTS(NUM_OBJECTS),
    .NUM_LABELS (NUM_LABELS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .object_slot   (object_slot),
    .label         (label),
    .result_valid  (result_valid),
    .winner_label  (winner_label),
    .winner_count  (winner_count),
    .bin_count     (bin_count),
    .winner_changed(winner_changed)
  );

  per_object_label_vote_checker #(
    .NUM_OBJECTS(NUM_OBJECTS),
    .NUM_LABELS (NUM_LABELS)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .object_slot   (object_slot),
    .label         (label),
    .result_valid  (result_valid),
    .winner_label  (winner_label),
    .winner_count  (winner_count),
    .bin_count     (bin_count),
    .winner_changed(winner_changed),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .changes_seen  (changes_seen)
  );

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // one vote, with random idle cycles ahead of it; returns once accepted
  task automatic cast_vote(input logic [SLOT_W-1:0] slot, input logic [LABEL_W-1:0] lab,
                           input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    object_slot <= slot;
    label       <= lab;
    do @(posedge clk); while (busy);
    votes_cast++;
  endtask

  // fresh set of contended slots and labels; label 0 is the reset winner
  task automatic pick_hot_set();
    foreach (hot_slots[i]) begin
      hot_slots[i]  = SLOT_W'($urandom_range(NUM_OBJECTS - 1));
      hot_labels[i] = (i == 0) ? '0 : LABEL_W'($urandom_range(NUM_LABELS - 1));
    end
  endtask

  // mostly votes piled on a few objects so winners shift and tie, the rest scattered
  task automatic random_votes(input int count, input int idle_pct);
    logic [SLOT_W-1:0]  slot;
    logic [LABEL_W-1:0] lab;
    pick_hot_set();
    repeat (count) begin
      if ($urandom_range(99) < 75) begin
        slot = hot_slots[$urandom_range(HOT - 1)];
        lab  = hot_labels[$urandom_range(HOT - 1)];
      end else begin
        slot = SLOT_W'($urandom);
        lab  = LABEL_W'($urandom);
      end
      cast_vote(slot, lab, idle_pct);
    end
  endtask

  // timeout
  initial begin
    #(64'd40_000_000);
    $display("per_object_label_vote_unit_test: errors");
    $finish;
  end

  // stimulus and verdict
  initial begin
    votes_cast  = 0;
    rst         = 1'b1;
    start       = 1'b0;
    object_slot = '0;
    label       = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: vote for the reset winner, a tie that keeps it, a takeover
    cast_vote(10'd0, 8'd0, 25);
    cast_vote(10'd0, 8'd5, 25);
    cast_vote(10'd0, 8'd5, 25);
    cast_vote(10'd0, 8'd0, 25);
    cast_vote(10'd0, 8'd0, 25);
    cast_vote(10'd0, 8'd5, 25);
    // extremes of slot and label, alternating bit patterns
    cast_vote(10'd1023, 8'd255, 25);
    cast_vote(10'd1023, 8'd0, 25);
    cast_vote(10'd1023, 8'd255, 25);
    cast_vote(10'd0, 8'd255, 25);
    cast_vote(10'd1023, 8'd1, 25);
    cast_vote(10'h155, 8'hAA, 25);
    cast_vote(10'h2AA, 8'h55, 25);
    cast_vote(10'h2AA, 8'hAA, 25);
    cast_vote(10'h2AA, 8'hAA, 25);
    cast_vote(10'd512, 8'd128, 25);
    cast_vote(10'd511, 8'd127, 25);

    // random votes under three pacing regimes
    random_votes(300, 25);
    random_votes(250, 83);
    random_votes(250, 0);
    start <= 1'b0;

    // drain outstanding results, then allow a few cycles for strays
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("votes cast: %0d (directed corner votes, then light, heavy and no sender gaps)",
             votes_cast);
    $display("results checked: %0d, winner changes seen: %0d, mismatches: %0d",
             results_seen, changes_seen, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("per_object_label_vote_unit_test: clean");
    end else begin
      $display("per_object_label_vote_unit_test: errors");
    end
    $finish;
  end

endmodule
